/* src/tcm_pkg.sv */
package tcm_pkg;

  localparam int COORD_W = 16;
  localparam int PROD_W  = 2 * COORD_W;
  localparam int ID_W    = 6;
  localparam int LINES_W = 8;
  localparam int ORIENT_W = 3;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam int FINGER_SCALE_DEF = 64;
  localparam int PEN_SCALE_DEF    = 260;

  // Largest sensor line count minus one; sets the width of a resolution.
  localparam int LINES_MAX_M1 = 254;

  localparam logic [ORIENT_W-1:0] ORIENT_RST = 3'd3;
  localparam logic [COORD_W-1:0]  PANEL_W_RST = 16'd1600;
  localparam logic [COORD_W-1:0]  PANEL_H_RST = 16'd2560;
  localparam logic [LINES_W-1:0]  TX_LINES_RST = 8'd36;
  localparam logic [LINES_W-1:0]  RX_LINES_RST = 8'd56;

  localparam logic [COORD_W-1:0] FIXED_PRESSURE = 16'd255;
  localparam logic [LINES_W-1:0] LINES_MIN = 8'd2;

  // Bit positions within orient_flags and the status byte.
  localparam int ORIENT_SWAP     = 0;
  localparam int ORIENT_MIRROR_X = 1;
  localparam int ORIENT_MIRROR_Y = 2;
  localparam int STATUS_TIP      = 0;
  localparam int STATUS_IN_RANGE = 1;
  localparam int STATUS_ID_LSB   = 2;

  typedef enum logic [2:0] {
    REG_ORIENT   = 3'd0,
    REG_PANEL_W  = 3'd1,
    REG_PANEL_H  = 3'd2,
    REG_TX_LINES = 3'd3,
    REG_RX_LINES = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [ORIENT_W-1:0] orient_flags;
    logic [COORD_W-1:0]  panel_width;
    logic [COORD_W-1:0]  panel_height;
    logic [LINES_W-1:0]  tx_lines;
    logic [LINES_W-1:0]  rx_lines;
  } cfg_t;

  // Record fields that ride alongside the divider chain.
  typedef struct packed {
    logic               touched;
    logic [ID_W-1:0]    finger_id;
    logic [COORD_W-1:0] pressure;
    logic               pen_in_range;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               skip;
  } meta_t;

endpackage

/* src/tcm_rec_if.sv */
interface tcm_rec_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  status_byte;
  logic [15:0] raw_x;
  logic [15:0] raw_y;
  logic [15:0] raw_pressure;

  modport source (output valid, mode, status_byte, raw_x, raw_y, raw_pressure,
                  input ready);
  modport sink (input valid, mode, status_byte, raw_x, raw_y, raw_pressure,
                output ready);
endinterface

/* src/tcm_res_if.sv */
interface tcm_res_if;
  logic        valid;
  logic        ready;
  logic        touched;
  logic [5:0]  finger_id;
  logic [15:0] out_x;
  logic [15:0] out_y;
  logic [15:0] out_pressure;
  logic        pen_in_range;

  modport source (output valid, touched, finger_id, out_x, out_y, out_pressure,
                  pen_in_range, input ready);
  modport sink (input valid, touched, finger_id, out_x, out_y, out_pressure,
                pen_in_range, output ready);
endinterface

/* src/touch_record_coordinate_map.sv */
// An accepted request passes through an input stage, 32 divider cells and
// an output register. Throughput: one record per cycle while the output
// is not stalled. The divider chain yields one quotient bit per cell over
// the 32-bit product of coordinate and panel size.
// Reset (synchronous, rst high) empties the pipeline and returns every
// configuration register to its default; no clearing pass is needed.
module touch_record_coordinate_map #(
  parameter int FINGER_SCALE = tcm_pkg::FINGER_SCALE_DEF,
  parameter int PEN_SCALE    = tcm_pkg::PEN_SCALE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tcm_pkg::ADDR_W-1:0] paddr,
  input  logic [tcm_pkg::DATA_W-1:0] pwdata,
  output logic [tcm_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  tcm_rec_if.sink                    record,
  tcm_res_if.source                  result
);
  import tcm_pkg::*;

  localparam int SCALE_MAX = (FINGER_SCALE > PEN_SCALE) ? FINGER_SCALE : PEN_SCALE;
  localparam int RES_W     = $clog2(LINES_MAX_M1 * SCALE_MAX + 1);
  localparam int NCELLS    = PROD_W;

  cfg_t cfg;
  logic en;

  logic                    st_valid [NCELLS+1];
  meta_t                   st_meta  [NCELLS+1];
  logic [1:0][PROD_W-1:0]  st_num   [NCELLS+1];
  logic [1:0][RES_W-1:0]   st_den   [NCELLS+1];
  logic [1:0][RES_W-1:0]   st_rem   [NCELLS+1];
  logic [1:0][COORD_W-1:0] st_quo   [NCELLS+1];

  // The whole chain advances together whenever the output register is free.
  assign en = !result.valid || result.ready;

  tcm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tcm_front #(
    .FINGER_SCALE (FINGER_SCALE),
    .PEN_SCALE    (PEN_SCALE),
    .RES_W        (RES_W)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .cfg    (cfg),
    .record (record),
    .valid  (st_valid[0]),
    .meta   (st_meta[0]),
    .num    (st_num[0]),
    .den    (st_den[0])
  );

  assign st_rem[0] = '0;
  assign st_quo[0] = '0;

  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    tcm_div_cell #(
      .RES_W (RES_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .valid_in (st_valid[k]),
      .meta_in  (st_meta[k]),
      .num_in   (st_num[k]),
      .den_in   (st_den[k]),
      .rem_in   (st_rem[k]),
      .quo_in   (st_quo[k]),
      .valid    (st_valid[k+1]),
      .meta     (st_meta[k+1]),
      .num      (st_num[k+1]),
      .den      (st_den[k+1]),
      .rem      (st_rem[k+1]),
      .quo      (st_quo[k+1])
    );
  end

  tcm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .cfg      (cfg),
    .valid_in (st_valid[NCELLS]),
    .meta_in  (st_meta[NCELLS]),
    .quo_in   (st_quo[NCELLS]),
    .result   (result)
  );

endmodule

/* src/tcm_regs.sv */
module tcm_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [tcm_pkg::ADDR_W-1:0] paddr,
  input  logic [tcm_pkg::DATA_W-1:0] pwdata,
  output logic [tcm_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  output tcm_pkg::cfg_t             cfg
);
  import tcm_pkg::*;

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.orient_flags <= ORIENT_RST;
      cfg.panel_width  <= PANEL_W_RST;
      cfg.panel_height <= PANEL_H_RST;
      cfg.tx_lines     <= TX_LINES_RST;
      cfg.rx_lines     <= RX_LINES_RST;
    end else if (wr_en) begin
      case (idx)
        REG_ORIENT:   cfg.orient_flags <= pwdata[ORIENT_W-1:0];
        REG_PANEL_W:  cfg.panel_width  <= pwdata[COORD_W-1:0];
        REG_PANEL_H:  cfg.panel_height <= pwdata[COORD_W-1:0];
        REG_TX_LINES: cfg.tx_lines     <= pwdata[LINES_W-1:0];
        REG_RX_LINES: cfg.rx_lines     <= pwdata[LINES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ORIENT:   prdata = DATA_W'(cfg.orient_flags);
      REG_PANEL_W:  prdata = DATA_W'(cfg.panel_width);
      REG_PANEL_H:  prdata = DATA_W'(cfg.panel_height);
      REG_TX_LINES: prdata = DATA_W'(cfg.tx_lines);
      REG_RX_LINES: prdata = DATA_W'(cfg.rx_lines);
      default:      prdata = '0;
    endcase
  end

`ifndef ASSERT_OFF
  a_orient_write: assert property (@(posedge clk) disable iff (rst)
    ($past(wr_en) && !$past(rst) && $past(idx) == REG_ORIENT) |->
      cfg.orient_flags == $past(pwdata[ORIENT_W-1:0]))
    else $error("orient_flags did not take the written value");
`endif

endmodule

/* src/tcm_front.sv */
module tcm_front #(
  parameter int FINGER_SCALE = tcm_pkg::FINGER_SCALE_DEF,
  parameter int PEN_SCALE    = tcm_pkg::PEN_SCALE_DEF,
  parameter int RES_W        = 18
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  tcm_pkg::cfg_t                       cfg,
  tcm_rec_if.sink                             record,
  output logic                                valid,
  output tcm_pkg::meta_t                      meta,
  output logic [1:0][tcm_pkg::PROD_W-1:0]     num,
  output logic [1:0][RES_W-1:0]               den
);
  import tcm_pkg::*;

  logic               touched;
  logic [COORD_W-1:0] sx, sy;
  logic [RES_W-1:0]   scale;
  logic [LINES_W-1:0] tx_m1, rx_m1;
  meta_t              meta_next;
  logic [1:0][PROD_W-1:0] num_next;
  logic [1:0][RES_W-1:0]  den_next;

  always_comb begin
    touched = record.status_byte[STATUS_TIP] | record.status_byte[STATUS_IN_RANGE];
    sx = cfg.orient_flags[ORIENT_SWAP] ? record.raw_y : record.raw_x;
    sy = cfg.orient_flags[ORIENT_SWAP] ? record.raw_x : record.raw_y;
    scale = record.mode ? RES_W'(PEN_SCALE) : RES_W'(FINGER_SCALE);
    tx_m1 = cfg.tx_lines - 8'd1;
    rx_m1 = cfg.rx_lines - 8'd1;

    num_next[0] = PROD_W'(sx) * PROD_W'(cfg.panel_width);
    num_next[1] = PROD_W'(sy) * PROD_W'(cfg.panel_height);
    den_next[0] = RES_W'(tx_m1) * scale;
    den_next[1] = RES_W'(rx_m1) * scale;

    meta_next.touched      = touched;
    meta_next.finger_id    = (touched && !record.mode) ?
                             record.status_byte[7:STATUS_ID_LSB] : '0;
    meta_next.pressure     = !touched ? '0 :
                             (record.mode ? record.raw_pressure : FIXED_PRESSURE);
    meta_next.pen_in_range = touched & record.mode &
                             record.status_byte[STATUS_IN_RANGE];
    meta_next.x            = sx;
    meta_next.y            = sy;
    meta_next.skip         = (cfg.tx_lines < LINES_MIN) || (cfg.rx_lines < LINES_MIN);
  end

  assign record.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= record.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta <= meta_next;
      num  <= num_next;
      den  <= den_next;
    end
  end

endmodule

/* src/tcm_div_cell.sv */
module tcm_div_cell #(
  parameter int RES_W = 18
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             valid_in,
  input  tcm_pkg::meta_t                   meta_in,
  input  logic [1:0][tcm_pkg::PROD_W-1:0]  num_in,
  input  logic [1:0][RES_W-1:0]            den_in,
  input  logic [1:0][RES_W-1:0]            rem_in,
  input  logic [1:0][tcm_pkg::COORD_W-1:0] quo_in,
  output logic                             valid,
  output tcm_pkg::meta_t                   meta,
  output logic [1:0][tcm_pkg::PROD_W-1:0]  num,
  output logic [1:0][RES_W-1:0]            den,
  output logic [1:0][RES_W-1:0]            rem,
  output logic [1:0][tcm_pkg::COORD_W-1:0] quo
);
  import tcm_pkg::*;

  logic [1:0][RES_W:0]    trial, diff;
  logic [1:0]             ge;
  logic [1:0][RES_W-1:0]  rem_next;
  logic [1:0][COORD_W-1:0] quo_next;
  logic [1:0][PROD_W-1:0] num_next;

  // One restoring step per lane: bring down the next dividend bit and
  // subtract the divisor if it fits. Only the low quotient bits are kept.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      trial[i]    = {rem_in[i], num_in[i][PROD_W-1]};
      diff[i]     = trial[i] - {1'b0, den_in[i]};
      ge[i]       = trial[i] >= {1'b0, den_in[i]};
      rem_next[i] = ge[i] ? diff[i][RES_W-1:0] : trial[i][RES_W-1:0];
      quo_next[i] = {quo_in[i][COORD_W-2:0], ge[i]};
      num_next[i] = {num_in[i][PROD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta <= meta_in;
      den  <= den_in;
      num  <= num_next;
      rem  <= rem_next;
      quo  <= quo_next;
    end
  end

`ifndef ASSERT_OFF
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (valid && !meta.skip) |-> (rem[0] < den[0]) && (rem[1] < den[1]))
    else $error("partial remainder not below the divisor");
`endif

endmodule

/* src/tcm_back.sv */
module tcm_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  tcm_pkg::cfg_t                   cfg,
  input  logic                            valid_in,
  input  tcm_pkg::meta_t                  meta_in,
  input  logic [1:0][tcm_pkg::COORD_W-1:0] quo_in,
  tcm_res_if.source                       result
);
  import tcm_pkg::*;

  logic [COORD_W-1:0] xs, ys, xm, ym;

  always_comb begin
    xs = meta_in.skip ? meta_in.x : quo_in[0];
    ys = meta_in.skip ? meta_in.y : quo_in[1];
    xm = cfg.orient_flags[ORIENT_MIRROR_X] ? cfg.panel_width - xs : xs;
    ym = cfg.orient_flags[ORIENT_MIRROR_Y] ? cfg.panel_height - ys : ys;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.touched      <= meta_in.touched;
      result.finger_id    <= meta_in.finger_id;
      result.out_x        <= meta_in.touched ? xm : '0;
      result.out_y        <= meta_in.touched ? ym : '0;
      result.out_pressure <= meta_in.pressure;
      result.pen_in_range <= meta_in.pen_in_range;
    end
  end

`ifndef ASSERT_OFF
  a_no_touch_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.touched) |->
      (result.out_x == '0) && (result.out_y == '0) &&
      (result.out_pressure == '0) && (result.finger_id == '0) && !result.pen_in_range)
    else $error("untouched record carries non-zero fields");
  a_pen_no_id: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.pen_in_range) |-> (result.finger_id == '0))
    else $error("pen record carries a finger id");
`endif

endmodule
